FILE: rtl/psa_pkg.sv
// psa_pkg: shared types and constants for the slot pool allocator.
// Used by psa_cell and pool_slot_allocator_oldest_recycle; no dependencies.
`timescale 1ns / 1ps

package psa_pkg;

	localparam int POOL_SLOTS_DEF = 16;
	localparam int SLOT_IN_W      = 4;
	localparam int POOL_SIZE_W    = 5;
	localparam logic [POOL_SIZE_W-1:0] POOL_SIZE_RST = 5'd16;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_ALLOC,
		OP_RECYCLE,
		OP_RELEASE
	} op_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic en;
		op_t  op;
		logic rel_ok;
	} ctrl_t;

endpackage

FILE: rtl/psa_cell.sv
// psa_cell: one slot of the pool plus one position of the age-ordered list.
// Depends on psa_pkg; chained by pool_slot_allocator_oldest_recycle.
`timescale 1ns / 1ps

module psa_cell #(
	parameter int POOL_SLOTS = psa_pkg::POOL_SLOTS_DEF,
	parameter int IDX        = 0,
	parameter int SLOT_W     = 4,
	parameter int CNT_W      = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  psa_pkg::ctrl_t                ctrl,
	input  logic [CNT_W-1:0]              count,
	input  logic [SLOT_W-1:0]             rel_idx,
	input  logic [SLOT_W-1:0]             app_val,
	input  logic [psa_pkg::POOL_SIZE_W-1:0] pool_size,
	input  logic                          free_in,
	input  logic                          shift_in,
	input  logic [SLOT_W-1:0]             gidx_in,
	input  logic [SLOT_W-1:0]             next_entry,
	output logic                          free_out,
	output logic                          shift_out,
	output logic [SLOT_W-1:0]             gidx_out,
	output logic [SLOT_W-1:0]             entry,
	output logic                          active
);

	localparam logic [SLOT_W-1:0] MY_IDX  = SLOT_W'(IDX);
	localparam logic [CNT_W-1:0]  MY_POS  = CNT_W'(IDX);
	localparam logic [CNT_W-1:0]  MY_POS1 = CNT_W'(IDX + 1);

	logic              active_q;
	logic [SLOT_W-1:0] entry_q;
	logic              eligible;
	logic              grant;
	logic              occupied;
	logic              match;
	logic              active_d;
	logic [SLOT_W-1:0] entry_d;

	assign eligible  = !active_q && (32'(IDX) < 32'(pool_size));
	assign grant     = eligible && !free_in;
	assign free_out  = free_in | eligible;
	assign gidx_out  = gidx_in | (grant ? MY_IDX : '0);
	assign occupied  = MY_POS < count;
	assign match     = ctrl.rel_ok && occupied && (entry_q == rel_idx);
	assign shift_out = shift_in | match;
	assign entry     = entry_q;
	assign active    = active_q;

	always_comb begin
		active_d = active_q;
		entry_d  = entry_q;
		unique case (ctrl.op)
			psa_pkg::OP_ALLOC: begin
				if (grant)
					active_d = 1'b1;
				if (MY_POS == count)
					entry_d = app_val;
			end
			psa_pkg::OP_RECYCLE: begin
				// head leaves, tail position takes it back
				if (MY_POS1 < count)
					entry_d = next_entry;
				else if (MY_POS1 == count)
					entry_d = app_val;
			end
			psa_pkg::OP_RELEASE: begin
				if (ctrl.rel_ok && (MY_IDX == rel_idx))
					active_d = 1'b0;
				if (shift_out)
					entry_d = next_entry;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			active_q <= 1'b0;
		else if (ctrl.en)
			active_q <= active_d;
	end

	always_ff @(posedge clk) begin
		if (ctrl.en)
			entry_q <= entry_d;
	end

endmodule

FILE: rtl/pool_slot_allocator_oldest_recycle.sv
// Channel   Dir  Handshake             Payload
// in        in   in_valid / in_ready   mode, slot
// out       out  out_valid / out_ready granted_slot, granted, recycled
// cfg       in   cfg_wr_en             cfg_wr_data (pool_size)
//
// Each item goes in order: first the request is captured, then one pass through the
// row of slot cells (free search and list shift ripple along the row) commits it.
// The next item is taken once that pass is done; a waiting result sits in the
// output register and only holds the pass back while it is still untaken.
// Reset: all slots inactive, list empty, pool_size 16.
// Depends on psa_pkg and psa_cell.
`timescale 1ns / 1ps

module pool_slot_allocator_oldest_recycle #(
	parameter int POOL_SLOTS = psa_pkg::POOL_SLOTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [psa_pkg::POOL_SIZE_W-1:0] cfg_wr_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            mode,
	input  logic [psa_pkg::SLOT_IN_W-1:0]   slot,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [psa_pkg::SLOT_IN_W-1:0]   granted_slot,
	output logic                            granted,
	output logic                            recycled
);

	localparam int SLOT_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
	localparam int CNT_W  = $clog2(POOL_SLOTS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(POOL_SLOTS);

	psa_pkg::state_t state_q, state_d;

	logic [psa_pkg::POOL_SIZE_W-1:0] pool_size_q;
	logic [CNT_W-1:0]                count_q;
	logic                            mode_q;
	logic [psa_pkg::SLOT_IN_W-1:0]   slot_q;

	logic                            out_valid_q;
	logic [psa_pkg::SLOT_IN_W-1:0]   granted_slot_q;
	logic                            granted_q;
	logic                            recycled_q;

	logic                            commit;
	psa_pkg::op_t                    op;
	psa_pkg::ctrl_t                  ctrl;
	logic [SLOT_W-1:0]               rel_idx;
	logic [SLOT_W-1:0]               app_val;
	logic [CNT_W-1:0]                count_d;

	logic [POOL_SLOTS:0]             free_c;
	logic [POOL_SLOTS:0]             shift_c;
	logic [SLOT_W-1:0]               gidx_c [POOL_SLOTS+1];
	logic [SLOT_W-1:0]               entry_a [POOL_SLOTS];
	logic [POOL_SLOTS-1:0]           active_a;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= psa_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		commit   = 1'b0;
		unique case (state_q)
			psa_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid)
					state_d = psa_pkg::ST_EXEC;
			end
			psa_pkg::ST_EXEC: begin
				if (!out_valid_q || out_ready) begin
					commit  = 1'b1;
					state_d = psa_pkg::ST_IDLE;
				end
			end
			default: state_d = psa_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_q <= mode;
			slot_q <= slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pool_size_q <= psa_pkg::POOL_SIZE_RST;
		else if (cfg_wr_en)
			pool_size_q <= cfg_wr_data;
	end

	// decode
	assign rel_idx = SLOT_W'(slot_q);

	always_comb begin
		if (mode_q)
			op = psa_pkg::OP_RELEASE;
		else if (free_c[POOL_SLOTS])
			op = psa_pkg::OP_ALLOC;
		else if (count_q != '0)
			op = psa_pkg::OP_RECYCLE;
		else
			op = psa_pkg::OP_NONE;
	end

	assign ctrl.en     = commit;
	assign ctrl.op     = op;
	assign ctrl.rel_ok = (32'(slot_q) < 32'(POOL_SLOTS));
	assign app_val     = (op == psa_pkg::OP_ALLOC) ? gidx_c[POOL_SLOTS] : entry_a[0];

	always_comb begin
		count_d = count_q;
		case (op)
			psa_pkg::OP_ALLOC:
				if (count_q < CNT_MAX)
					count_d = count_q + CNT_W'(1);
			psa_pkg::OP_RELEASE:
				if (shift_c[POOL_SLOTS])
					count_d = count_q - CNT_W'(1);
			default: count_d = count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= '0;
		else if (commit)
			count_q <= count_d;
	end

	// cell row
	assign free_c[0]  = 1'b0;
	assign shift_c[0] = 1'b0;
	assign gidx_c[0]  = '0;

	for (genvar k = 0; k < POOL_SLOTS; k++) begin : g_cell
		logic [SLOT_W-1:0] nxt;
		if (k < POOL_SLOTS - 1) begin : g_mid
			assign nxt = entry_a[k+1];
		end else begin : g_end
			assign nxt = entry_a[k];
		end

		psa_cell #(
			.POOL_SLOTS (POOL_SLOTS),
			.IDX        (k),
			.SLOT_W     (SLOT_W),
			.CNT_W      (CNT_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.count      (count_q),
			.rel_idx    (rel_idx),
			.app_val    (app_val),
			.pool_size  (pool_size_q),
			.free_in    (free_c[k]),
			.shift_in   (shift_c[k]),
			.gidx_in    (gidx_c[k]),
			.next_entry (nxt),
			.free_out   (free_c[k+1]),
			.shift_out  (shift_c[k+1]),
			.gidx_out   (gidx_c[k+1]),
			.entry      (entry_a[k]),
			.active     (active_a[k])
		);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (commit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			case (op)
				psa_pkg::OP_ALLOC: begin
					granted_slot_q <= psa_pkg::SLOT_IN_W'(gidx_c[POOL_SLOTS]);
					granted_q      <= 1'b1;
					recycled_q     <= 1'b0;
				end
				psa_pkg::OP_RECYCLE: begin
					granted_slot_q <= psa_pkg::SLOT_IN_W'(entry_a[0]);
					granted_q      <= 1'b1;
					recycled_q     <= 1'b1;
				end
				default: begin
					granted_slot_q <= '0;
					granted_q      <= 1'b0;
					recycled_q     <= 1'b0;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign granted_slot = granted_slot_q;
	assign granted      = granted_q;
	assign recycled     = recycled_q;

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("list count above capacity");

	a_active_listed: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(active_a) == 32'(count_q))
		else $error("active slots and list length disagree");

	a_result_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == psa_pkg::ST_EXEC))
		else $error("result without a cell pass");

	a_recycle_grants: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && recycled_q) |-> granted_q)
		else $error("recycle without grant");
`endif

endmodule
